@@ hw/rtl/rsa_ped_pkg.sv @@
`default_nettype none
package rsa_ped_pkg;

   localparam int FIELD_W            = 31;
   localparam int OUT_W              = 62;
   localparam int WORD_W             = 64;
   localparam int CNT_W              = 7;
   localparam int PRIME_BITS_DEFAULT = 31;

   typedef struct packed {
      logic [FIELD_W-1:0] first_prime;
      logic [FIELD_W-1:0] second_prime;
      logic [FIELD_W-1:0] public_exponent;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] modulus;
      logic [OUT_W-1:0] totient;
      logic [OUT_W-1:0] private_exponent;
      logic [OUT_W-1:0] common_divisor;
      logic             invertible;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_MUL_STEP,
      CMD_STORE_N,
      CMD_STORE_PHI,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_ROUND_END,
      CMD_NORM_INIT,
      CMD_NORM_END,
      CMD_PUBLISH
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_N,
      S_STORE_N,
      S_MUL_PHI,
      S_STORE_PHI,
      S_CHECK,
      S_DIV,
      S_ROUND_END,
      S_NORM,
      S_NORM_END,
      S_DONE
   } state_type;

   typedef struct packed {
      logic b_zero;
      logic c0_neg;
      logic phi_zero;
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/rsa_ped_datapath.sv @@
`default_nettype none
module rsa_ped_datapath import rsa_ped_pkg::*; #(
   parameter int PRIME_BITS = PRIME_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire req_type req_payload,
   input  wire cmd_type cmd,
   output status_type   status,
   output rsp_type      rsp_payload
);

   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [WORD_W-1:0] n_ff, n_in, phi_ff, phi_in, acc_ff, acc_in;
   logic [WORD_W-1:0] mb_ff, mb_in, md_ff, md_in, dvd_ff, dvd_in, rem_ff, rem_in;
   logic [PRIME_BITS-1:0] p_ff, p_in, q_ff, q_in;
   logic [FIELD_W-1:0]    e_ff, e_in;
   rsp_type               rsp_ff, rsp_in;

   logic [WORD_W+FIELD_W-1:0] p_ext, q_ext;
   logic [PRIME_BITS-1:0]     p_dec, q_dec;
   logic [WORD_W:0]           rem_sh, rem_sub;
   logic                      qbit;
   logic [WORD_W-1:0]         acc_sh;

   // mask the factors to the configured prime width
   assign p_ext = {{WORD_W{1'b0}}, req_payload.first_prime};
   assign q_ext = {{WORD_W{1'b0}}, req_payload.second_prime};
   assign p_dec = (p_ff == '0) ? '0 : p_ff - PRIME_BITS'(1);
   assign q_dec = (q_ff == '0) ? '0 : q_ff - PRIME_BITS'(1);

   // one restoring division step; quotient bit drives the Horner product
   assign rem_sh  = {rem_ff, dvd_ff[WORD_W-1]};
   assign rem_sub = rem_sh - {1'b0, b_ff};
   assign qbit    = !rem_sub[WORD_W];
   assign acc_sh  = {acc_ff[WORD_W-2:0], 1'b0};

   always_comb begin
      a_in   = a_ff;   b_in   = b_ff;   c0_in  = c0_ff;  c1_in  = c1_ff;
      n_in   = n_ff;   phi_in = phi_ff; acc_in = acc_ff;
      mb_in  = mb_ff;  md_in  = md_ff;  dvd_in = dvd_ff; rem_in = rem_ff;
      p_in   = p_ff;   q_in   = q_ff;   e_in   = e_ff;   rsp_in = rsp_ff;
      case (cmd)
         CMD_LOAD: begin
            p_in   = p_ext[PRIME_BITS-1:0];
            q_in   = q_ext[PRIME_BITS-1:0];
            e_in   = req_payload.public_exponent;
            mb_in  = {p_ext[PRIME_BITS-1:0], {(WORD_W-PRIME_BITS){1'b0}}};
            md_in  = WORD_W'(q_ext[PRIME_BITS-1:0]);
            acc_in = '0;
         end
         CMD_MUL_STEP: begin
            acc_in = acc_sh + (mb_ff[WORD_W-1] ? md_ff : '0);
            mb_in  = {mb_ff[WORD_W-2:0], 1'b0};
         end
         CMD_STORE_N: begin
            n_in   = acc_ff;
            mb_in  = {p_dec, {(WORD_W-PRIME_BITS){1'b0}}};
            md_in  = WORD_W'(q_dec);
            acc_in = '0;
         end
         CMD_STORE_PHI: begin
            phi_in = acc_ff;
            b_in   = acc_ff;
            a_in   = WORD_W'(e_ff);
            c0_in  = WORD_W'(1);
            c1_in  = '0;
         end
         CMD_DIV_INIT: begin
            rem_in = '0;
            dvd_in = a_ff;
            acc_in = '0;
         end
         CMD_DIV_STEP: begin
            rem_in = qbit ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
            acc_in = acc_sh + (qbit ? c1_ff : '0);
         end
         CMD_ROUND_END: begin
            a_in  = b_ff;
            b_in  = rem_ff;
            c0_in = c1_ff;
            c1_in = c0_ff - acc_ff;
         end
         CMD_NORM_INIT: begin
            rem_in = '0;
            dvd_in = '0 - c0_ff;
            b_in   = phi_ff;
            acc_in = '0;
         end
         CMD_NORM_END: begin
            c0_in = (rem_ff == '0) ? '0 : phi_ff - rem_ff;
         end
         CMD_PUBLISH: begin
            rsp_in.modulus          = n_ff[OUT_W-1:0];
            rsp_in.totient          = phi_ff[OUT_W-1:0];
            rsp_in.private_exponent = c0_ff[OUT_W-1:0];
            rsp_in.common_divisor   = a_ff[OUT_W-1:0];
            rsp_in.invertible       = (a_ff == WORD_W'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;   b_ff   <= b_in;   c0_ff  <= c0_in;  c1_ff  <= c1_in;
      n_ff   <= n_in;   phi_ff <= phi_in; acc_ff <= acc_in;
      mb_ff  <= mb_in;  md_ff  <= md_in;  dvd_ff <= dvd_in; rem_ff <= rem_in;
      p_ff   <= p_in;   q_ff   <= q_in;   e_ff   <= e_in;   rsp_ff <= rsp_in;
   end

   assign status.b_zero   = (b_ff == '0);
   assign status.c0_neg   = c0_ff[WORD_W-1];
   assign status.phi_zero = (phi_ff == '0);
   assign rsp_payload     = rsp_ff;

endmodule
`default_nettype wire

@@ hw/rtl/rsa_ped_controller.sv @@
`default_nettype none
module rsa_ped_controller import rsa_ped_pkg::*; #(
   parameter int PRIME_BITS = PRIME_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             mul_last, div_last, slot_free;

   assign mul_last  = (cnt_ff == CNT_W'(PRIME_BITS - 1));
   assign div_last  = (cnt_ff == CNT_W'(WORD_W - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) state_in = S_MUL_N;
         end
         S_MUL_N:     if (mul_last) state_in = S_STORE_N;
         S_STORE_N: begin
            cnt_in   = '0;
            state_in = S_MUL_PHI;
         end
         S_MUL_PHI:   if (mul_last) state_in = S_STORE_PHI;
         S_STORE_PHI: state_in = S_CHECK;
         S_CHECK: begin
            cnt_in = '0;
            if (!status.b_zero) state_in = S_DIV;
            else if (status.c0_neg && !status.phi_zero) state_in = S_NORM;
            else state_in = S_DONE;
         end
         S_DIV:       if (div_last) state_in = S_ROUND_END;
         S_ROUND_END: state_in = S_CHECK;
         S_NORM:      if (div_last) state_in = S_NORM_END;
         S_NORM_END:  state_in = S_DONE;
         S_DONE:      if (slot_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath command per state
   always_comb begin
      cmd = CMD_IDLE;
      case (state_ff)
         S_IDLE:      if (req_valid) cmd = CMD_LOAD;
         S_MUL_N:     cmd = CMD_MUL_STEP;
         S_STORE_N:   cmd = CMD_STORE_N;
         S_MUL_PHI:   cmd = CMD_MUL_STEP;
         S_STORE_PHI: cmd = CMD_STORE_PHI;
         S_CHECK: begin
            if (!status.b_zero) cmd = CMD_DIV_INIT;
            else if (status.c0_neg && !status.phi_zero) cmd = CMD_NORM_INIT;
         end
         S_DIV:       cmd = CMD_DIV_STEP;
         S_ROUND_END: cmd = CMD_ROUND_END;
         S_NORM:      cmd = CMD_DIV_STEP;
         S_NORM_END:  cmd = CMD_NORM_END;
         S_DONE:      if (slot_free) cmd = CMD_PUBLISH;
         default:     cmd = CMD_IDLE;
      endcase
   end

   // hold the result valid until taken; a new publish wins
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd == CMD_PUBLISH) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV || state_ff == S_NORM) |-> cnt_ff <= CNT_W'(WORD_W - 1))
      else $error("division step count overran");
   a_publish: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_PUBLISH) |=> rsp_valid_ff)
      else $error("published result not marked valid");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL_N && cnt_ff == '0))
      else $error("accepted request did not start the product");
   a_div_cmd: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_DIV_STEP) |-> !(state_ff == S_IDLE || state_ff == S_DONE))
      else $error("division step outside a division phase");

endmodule
`default_nettype wire

@@ hw/rtl/rsa_private_exponent_derive_top.sv @@
`default_nettype none
// RSA private exponent derivation. A request carries p, q and e; the response
// gives n = p*q, the totient (p-1)(q-1), d = e^-1 mod totient (the extended
// Euclid coefficient of e lifted to be nonnegative), gcd(e, totient) and an
// invertible flag. One request is worked at a time on a single shift-add
// unit: the two products first, then one Euclid round after another (a
// restoring division with the quotient-times-coefficient product folded into
// the same steps), then a final reduction when the coefficient is negative,
// plus the store, check and publish steps and any wait while the previous
// response is still untaken. A finished response sits in an output register,
// so the next request is taken while it waits.
module rsa_private_exponent_derive_top import rsa_ped_pkg::*; #(
   parameter int PRIME_BITS = PRIME_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   cmd_type    cmd;
   status_type status;

   rsa_ped_controller #(.PRIME_BITS(PRIME_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsa_ped_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
